// File: sv/wrld_pkg.sv
// Package for the word run-length decoder.
// Holds the decoder phase type and the stream constants; depends on nothing.

package wrld_pkg;

   // Decoder phase: which byte of the stream is expected next.
   typedef enum logic [2:0] {
      PH_PLANE_HDR = 3'd0,
      PH_HDR       = 3'd1,
      PH_REP_HI    = 3'd2,
      PH_REP_LO    = 3'd3,
      PH_LIT_HI    = 3'd4,
      PH_LIT_LO    = 3'd5
   } phase_type;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned COUNT_W = 8;

   // Header bytes at or above this value start a literal run.
   localparam logic [BYTE_W-1:0] LIT_HDR_MIN = 8'h80;

   // Plane length after reset.
   localparam logic [WORD_W-1:0] PLANE_WORDS_RST = 16'd1;

endpackage

// File: sv/word_run_length_decoder.sv
// Word run-length decoder top level.
// Decodes a signed-header run-length byte stream into 16-bit word runs; uses wrld_pkg.

// The decoder takes one stream byte per cycle and never stalls on its own:
// req_stall is raised only while a word waits in the result register and the
// consumer stalls it. A header byte x >= 0 gives one result carrying the next
// word with a count of x+1; a header x < 0 gives -x results of count 1. Runs
// are cut to the words still missing from the plane, and the result that
// completes the plane carries rsp_last_of_plane. Header bytes and first word
// bytes give no result, so a word appears in the cycle after its second byte.
// A new plane_words value takes effect at the next plane's first header.

module word_run_length_decoder (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // Decoded words out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_word_value,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_last_of_plane
);

   // State registers and their next values.
   wrld_pkg::phase_type                  phase_ff, phase_in;
   logic [wrld_pkg::COUNT_W-1:0]         run_left_ff, run_left_in;
   logic [wrld_pkg::BYTE_W-1:0]          high_byte_ff, high_byte_in;
   logic [wrld_pkg::WORD_W-1:0]          words_left_ff, words_left_in;
   logic [wrld_pkg::WORD_W-1:0]          plane_words_ff;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [wrld_pkg::WORD_W-1:0]          word_value_ff;
   logic [wrld_pkg::COUNT_W-1:0]         repeat_count_ff;
   logic                                 last_ff;

   // Decode outputs for the current byte.
   logic                                 accept;
   logic                                 word_done;
   logic [wrld_pkg::COUNT_W-1:0]         word_count;
   logic [wrld_pkg::WORD_W-1:0]          words_after;
   logic                                 word_last;
   logic [wrld_pkg::WORD_W-1:0]          wl_base;
   logic [wrld_pkg::COUNT_W-1:0]         want;

   // The byte side waits only while a finished word is held by the consumer.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Words left and run length at a header; a plane start reloads the plane length.
   always_comb begin
      if (phase_ff == wrld_pkg::PH_PLANE_HDR) begin
         wl_base = (plane_words_ff == '0) ? wrld_pkg::PLANE_WORDS_RST : plane_words_ff;
      end else begin
         wl_base = words_left_ff;
      end
      if (req_data_byte < wrld_pkg::LIT_HDR_MIN) begin
         want = req_data_byte + 8'd1;
      end else begin
         want = 8'd0 - req_data_byte;
      end
      // Clamp the run to the words still missing.
      if ({8'd0, want} > wl_base) begin
         want = wl_base[wrld_pkg::COUNT_W-1:0];
      end
   end

   // Phase sequencing and word completion.
   always_comb begin
      phase_in      = phase_ff;
      run_left_in   = run_left_ff;
      high_byte_in  = high_byte_ff;
      words_left_in = words_left_ff;
      word_done     = 1'b0;
      word_count    = 8'd1;
      case (phase_ff)
         wrld_pkg::PH_PLANE_HDR, wrld_pkg::PH_HDR: begin
            words_left_in = wl_base;
            run_left_in   = want;
            phase_in      = (req_data_byte < wrld_pkg::LIT_HDR_MIN) ?
                            wrld_pkg::PH_REP_HI : wrld_pkg::PH_LIT_HI;
         end
         wrld_pkg::PH_REP_HI: begin
            high_byte_in = req_data_byte;
            phase_in     = wrld_pkg::PH_REP_LO;
         end
         wrld_pkg::PH_REP_LO: begin
            word_done   = 1'b1;
            word_count  = run_left_ff;
            run_left_in = '0;
            phase_in    = wrld_pkg::PH_HDR;
         end
         wrld_pkg::PH_LIT_HI: begin
            high_byte_in = req_data_byte;
            phase_in     = wrld_pkg::PH_LIT_LO;
         end
         wrld_pkg::PH_LIT_LO: begin
            word_done   = 1'b1;
            run_left_in = run_left_ff - 8'd1;
            phase_in    = (run_left_in == '0) ? wrld_pkg::PH_HDR : wrld_pkg::PH_LIT_HI;
         end
         default: begin
            phase_in = wrld_pkg::PH_PLANE_HDR;
         end
      endcase

      words_after = words_left_ff - {8'd0, word_count};
      word_last   = (words_after == '0);
      if (word_done) begin
         words_left_in = words_after;
         // The word that completes the plane ends any run in progress.
         if (word_last) begin
            run_left_in = '0;
            phase_in    = wrld_pkg::PH_PLANE_HDR;
         end
      end
   end

   // Result register valid: loaded by a finished word, cleared when taken.
   always_comb begin
      if (accept && word_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= wrld_pkg::PH_PLANE_HDR;
         run_left_ff    <= '0;
         high_byte_ff   <= '0;
         words_left_ff  <= wrld_pkg::PLANE_WORDS_RST;
         plane_words_ff <= wrld_pkg::PLANE_WORDS_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            run_left_ff   <= run_left_in;
            high_byte_ff  <= high_byte_in;
            words_left_ff <= words_left_in;
         end
         if (csr_wr_en) begin
            plane_words_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept && word_done) begin
         word_value_ff   <= {high_byte_ff, req_data_byte};
         repeat_count_ff <= word_count;
         last_ff         <= word_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word_value    = word_value_ff;
   assign rsp_repeat_count  = repeat_count_ff;
   assign rsp_last_of_plane = last_ff;

   // A delivered word always covers at least one position of the plane.
   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (repeat_count_ff != '0))
      else $error("result word with zero repeat count");

   // Inside a run there is always a word pending and it fits the plane.
   a_run_fits : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wrld_pkg::PH_REP_HI || phase_ff == wrld_pkg::PH_REP_LO ||
       phase_ff == wrld_pkg::PH_LIT_HI || phase_ff == wrld_pkg::PH_LIT_LO)
      |-> (run_left_ff != '0) && ({8'd0, run_left_ff} <= words_left_ff))
      else $error("run length empty or beyond the plane");

   // The word that completes a plane sends the decoder back to a plane header.
   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      (accept && word_done && word_last) |=>
      (phase_ff == wrld_pkg::PH_PLANE_HDR) && rsp_valid_ff && last_ff)
      else $error("plane end did not restart the decoder");

   // A byte is never taken while a finished word is held back.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(word_value_ff))
      else $error("held result word overwritten");

endmodule
